@@ rtl/epc_pkg.sv @@
package epc_pkg;

    localparam int COORD_W            = 32;
    localparam int SCORE_W            = 17;
    localparam int LEN_FRAC           = 16;
    localparam int SCORE_FRAC_DEFAULT = 16;

    // segment deltas, midpoint-sum deltas and their products
    localparam int D_W   = COORD_W + 1;
    localparam int M_W   = COORD_W + 2;
    localparam int N_W   = D_W + M_W + 1;
    localparam int L2_W  = 2 * D_W;
    localparam int M2_W  = 2 * M_W;
    localparam int SQX_W = M2_W + 2 * LEN_FRAC;
    localparam int SQ_W  = SQX_W / 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd39322;

    typedef enum logic [0:0] {
        REG_SCORE_THRESHOLD = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] p_start_x;
        logic signed [COORD_W-1:0] p_start_y;
        logic signed [COORD_W-1:0] p_end_x;
        logic signed [COORD_W-1:0] p_end_y;
        logic signed [COORD_W-1:0] q_start_x;
        logic signed [COORD_W-1:0] q_start_y;
        logic signed [COORD_W-1:0] q_end_x;
        logic signed [COORD_W-1:0] q_end_y;
    } in_t;

    typedef struct packed {
        logic               compatible;
        logic [SCORE_W-1:0] score;
        logic               degenerate;
    } out_t;

endpackage

@@ rtl/edge_pair_compatibility_top.sv @@
// channel   dir  handshake               payload
// s_        in   s_valid / s_ready       s_data  (epc_pkg::in_t, two segments)
// m_        out  m_valid / m_ready       m_data  (epc_pkg::out_t, score and flags)
// apb       in   psel/penable/pwrite     paddr, pwdata, prdata (score_threshold at 0x0)
//
// One pair per cycle while the output is not stalled; the pipeline depth is
// set by the bit-per-stage square root (SQ_W stages) and the bit-per-stage dividers.
// Reset clears the stage valid bits and loads the threshold; no clearing pass.
// A stalled result holds the whole pipeline in place; s_ready drops only while
// the output register is full and m_ready is low.
module edge_pair_compatibility_top #(
    parameter int SCORE_FRAC_BITS = epc_pkg::SCORE_FRAC_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  epc_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output epc_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epc_pkg::APB_AW-1:0]  paddr,
    input  logic [epc_pkg::APB_DW-1:0]  pwdata,
    output logic [epc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import epc_pkg::*;

    localparam int SFB   = SCORE_FRAC_BITS;
    localparam int T_W   = SFB + 1;
    localparam int H_W   = (SQ_W + 1) / 2;
    localparam int P_W   = 4 * H_W;
    localparam int DV_W  = 2 * SQ_W + 2 + SFB;
    localparam int DV_N  = SFB + 3;
    localparam int CMP_W = (T_W > SCORE_W) ? T_W : SCORE_W;
    localparam logic [T_W-1:0] ONE = T_W'(1) << SFB;

    localparam int MUL_LL = 0;   // lp * lq
    localparam int MUL_AS = 1;   // a * s
    localparam int MUL_SS = 2;   // s * s
    localparam int MUL_AB = 3;   // a * b
    localparam int DIV_ANG = 0;
    localparam int DIV_SCL = 1;
    localparam int DIV_POS = 2;
    localparam int DIV_VIS = 3;

    logic adv;
    logic out_v_reg;
    out_t out_reg;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // ---------------- configuration
    logic [SCORE_W-1:0] thr_reg;
    reg_idx_t           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
        end else if (psel && penable && pwrite && reg_idx == REG_SCORE_THRESHOLD) begin
            thr_reg <= pwdata[SCORE_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SCORE_THRESHOLD: prdata = APB_DW'(thr_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- stage 1: deltas
    logic signed [D_W-1:0] dpx_reg, dpy_reg, dqx_reg, dqy_reg;
    logic signed [M_W-1:0] mx_reg, my_reg;
    logic                  v1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dpx_reg <= D_W'(s_data.p_end_x) - D_W'(s_data.p_start_x);
            dpy_reg <= D_W'(s_data.p_end_y) - D_W'(s_data.p_start_y);
            dqx_reg <= D_W'(s_data.q_end_x) - D_W'(s_data.q_start_x);
            dqy_reg <= D_W'(s_data.q_end_y) - D_W'(s_data.q_start_y);
            mx_reg  <= M_W'(s_data.q_start_x) + M_W'(s_data.q_end_x)
                     - M_W'(s_data.p_start_x) - M_W'(s_data.p_end_x);
            my_reg  <= M_W'(s_data.q_start_y) + M_W'(s_data.q_end_y)
                     - M_W'(s_data.p_start_y) - M_W'(s_data.p_end_y);
        end
    end

    // ---------------- stage 2: products
    logic signed [2*D_W-1:0]   pdq_x_reg, pdq_y_reg, pp_x_reg, pp_y_reg, qq_x_reg, qq_y_reg;
    logic signed [2*M_W-1:0]   mm_x_reg, mm_y_reg;
    logic signed [D_W+M_W-1:0] mp_x_reg, mp_y_reg, mq_x_reg, mq_y_reg;
    logic                      v2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pdq_x_reg <= dpx_reg * dqx_reg;
            pdq_y_reg <= dpy_reg * dqy_reg;
            pp_x_reg  <= dpx_reg * dpx_reg;
            pp_y_reg  <= dpy_reg * dpy_reg;
            qq_x_reg  <= dqx_reg * dqx_reg;
            qq_y_reg  <= dqy_reg * dqy_reg;
            mm_x_reg  <= mx_reg * mx_reg;
            mm_y_reg  <= my_reg * my_reg;
            mp_x_reg  <= mx_reg * dpx_reg;
            mp_y_reg  <= my_reg * dpy_reg;
            mq_x_reg  <= mx_reg * dqx_reg;
            mq_y_reg  <= my_reg * dqy_reg;
        end
    end

    // ---------------- stage 3: dot products, squared lengths
    logic signed [N_W-1:0] dot_c, np_c, nq_c;
    logic [L2_W-1:0]       lp2_c, lq2_c;
    logic [N_W-1:0]        adot_reg, np_reg, nq_reg;
    logic [L2_W-1:0]       lp2_reg, lq2_reg;
    logic [M2_W-1:0]       m2_reg;
    logic                  deg3_reg, v3_reg;

    always_comb begin
        dot_c = N_W'(pdq_x_reg) + N_W'(pdq_y_reg);
        np_c  = N_W'(mp_x_reg) + N_W'(mp_y_reg);
        nq_c  = N_W'(mq_x_reg) + N_W'(mq_y_reg);
        lp2_c = $unsigned(pp_x_reg) + $unsigned(pp_y_reg);
        lq2_c = $unsigned(qq_x_reg) + $unsigned(qq_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            adot_reg <= $unsigned(dot_c[N_W-1] ? -dot_c : dot_c);
            np_reg   <= $unsigned(np_c[N_W-1] ? -np_c : np_c);
            nq_reg   <= $unsigned(nq_c[N_W-1] ? -nq_c : nq_c);
            lp2_reg  <= lp2_c;
            lq2_reg  <= lq2_c;
            m2_reg   <= $unsigned(mm_x_reg) + $unsigned(mm_y_reg);
            deg3_reg <= (lp2_c == '0) || (lq2_c == '0) || (dot_c == '0);
        end
    end

    // ---------------- square roots, one root bit per stage; index 0 loads operands
    logic [SQX_W-1:0] sq_rem_reg  [SQ_W+1][3];
    logic [SQ_W-1:0]  sq_root_reg [SQ_W+1][3];
    logic [N_W-1:0]   sq_adot_reg [SQ_W+1];
    logic [N_W-1:0]   sq_visn_reg [SQ_W+1];
    logic             sq_visz_reg [SQ_W+1];
    logic             sq_deg_reg  [SQ_W+1];
    logic             sq_v_reg    [SQ_W+1];
    logic [N_W-1:0]   nmax_c;

    assign nmax_c = (np_reg >= nq_reg) ? np_reg : nq_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            // lengths carry LEN_FRAC extra fraction bits; dm is twice the midpoint distance
            sq_rem_reg[0][0]  <= SQX_W'(lp2_reg) << (2 * LEN_FRAC);
            sq_rem_reg[0][1]  <= SQX_W'(lq2_reg) << (2 * LEN_FRAC);
            sq_rem_reg[0][2]  <= SQX_W'(m2_reg) << (2 * LEN_FRAC);
            sq_root_reg[0][0] <= '0;
            sq_root_reg[0][1] <= '0;
            sq_root_reg[0][2] <= '0;
            sq_adot_reg[0]    <= adot_reg;
            sq_visn_reg[0]    <= adot_reg - nmax_c;
            sq_visz_reg[0]    <= nmax_c >= adot_reg;
            sq_deg_reg[0]     <= deg3_reg;
        end
    end

    for (genvar k = 1; k <= SQ_W; k++) begin : g_sqrt
        localparam int B = SQ_W - k;
        for (genvar j = 0; j < 3; j++) begin : g_unit
            logic [SQX_W-1:0] trial;
            logic             fits;
            // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B); r has no bits below B+1
            always_comb begin
                trial = (SQX_W'(sq_root_reg[k-1][j]) << (B + 1)) | (SQX_W'(1) << (2 * B));
                fits  = sq_rem_reg[k-1][j] >= trial;
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_rem_reg[k][j]  <= fits ? sq_rem_reg[k-1][j] - trial
                                              : sq_rem_reg[k-1][j];
                    sq_root_reg[k][j] <= fits ? (sq_root_reg[k-1][j] | (SQ_W'(1) << B))
                                              : sq_root_reg[k-1][j];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_adot_reg[k] <= sq_adot_reg[k-1];
                sq_visn_reg[k] <= sq_visn_reg[k-1];
                sq_visz_reg[k] <= sq_visz_reg[k-1];
                sq_deg_reg[k]  <= sq_deg_reg[k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
        end
    end

    // ---------------- E1: min / max / sum, multiplier operands
    logic [SQ_W-1:0] lp_c, lq_c, a_c, b_c, s_c;
    logic [SQ_W-1:0] mop_a_reg [4];
    logic [SQ_W-1:0] mop_b_reg [4];
    logic [SQ_W-1:0] s_e1_reg, dm_e1_reg;
    logic [N_W-1:0]  adot_e1_reg, visn_e1_reg;
    logic            visz_e1_reg, deg_e1_reg, v_e1_reg;

    always_comb begin
        lp_c = sq_root_reg[SQ_W][0];
        lq_c = sq_root_reg[SQ_W][1];
        a_c  = (lp_c < lq_c) ? lp_c : lq_c;
        b_c  = (lp_c < lq_c) ? lq_c : lp_c;
        s_c  = a_c + b_c;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mop_a_reg[MUL_LL] <= lp_c;
            mop_b_reg[MUL_LL] <= lq_c;
            mop_a_reg[MUL_AS] <= a_c;
            mop_b_reg[MUL_AS] <= s_c;
            mop_a_reg[MUL_SS] <= s_c;
            mop_b_reg[MUL_SS] <= s_c;
            mop_a_reg[MUL_AB] <= a_c;
            mop_b_reg[MUL_AB] <= b_c;
            s_e1_reg          <= s_c;
            dm_e1_reg         <= sq_root_reg[SQ_W][2];
            adot_e1_reg       <= sq_adot_reg[SQ_W];
            visn_e1_reg       <= sq_visn_reg[SQ_W];
            visz_e1_reg       <= sq_visz_reg[SQ_W];
            deg_e1_reg        <= sq_deg_reg[SQ_W];
        end
    end

    // ---------------- E2: half-width partial products
    logic [2*H_W-1:0] pp_reg [4][4];
    logic [SQ_W-1:0]  s_e2_reg, dm_e2_reg;
    logic [N_W-1:0]   adot_e2_reg, visn_e2_reg;
    logic             visz_e2_reg, deg_e2_reg, v_e2_reg;

    for (genvar m = 0; m < 4; m++) begin : g_pp
        logic [2*H_W-1:0] oa, ob;
        assign oa = (2*H_W)'(mop_a_reg[m]);
        assign ob = (2*H_W)'(mop_b_reg[m]);
        always_ff @(posedge aclk) begin
            if (adv) begin
                pp_reg[m][0] <= oa[2*H_W-1:H_W] * ob[2*H_W-1:H_W];
                pp_reg[m][1] <= oa[2*H_W-1:H_W] * ob[H_W-1:0];
                pp_reg[m][2] <= oa[H_W-1:0] * ob[2*H_W-1:H_W];
                pp_reg[m][3] <= oa[H_W-1:0] * ob[H_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_e2_reg    <= s_e1_reg;
            dm_e2_reg   <= dm_e1_reg;
            adot_e2_reg <= adot_e1_reg;
            visn_e2_reg <= visn_e1_reg;
            visz_e2_reg <= visz_e1_reg;
            deg_e2_reg  <= deg_e1_reg;
        end
    end

    // ---------------- E3: product sums
    logic [P_W-1:0]  prod_reg [4];
    logic [SQ_W-1:0] s_e3_reg, dm_e3_reg;
    logic [N_W-1:0]  adot_e3_reg, visn_e3_reg;
    logic            visz_e3_reg, deg_e3_reg, v_e3_reg;

    for (genvar m = 0; m < 4; m++) begin : g_psum
        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[m] <= (P_W'(pp_reg[m][0]) << (2 * H_W))
                             + ((P_W'(pp_reg[m][1]) + P_W'(pp_reg[m][2])) << H_W)
                             + P_W'(pp_reg[m][3]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_e3_reg    <= s_e2_reg;
            dm_e3_reg   <= dm_e2_reg;
            adot_e3_reg <= adot_e2_reg;
            visn_e3_reg <= visn_e2_reg;
            visz_e3_reg <= visz_e2_reg;
            deg_e3_reg  <= deg_e2_reg;
        end
    end

    // ---------------- dividers: index 0 loads, 1 checks overflow, then one quotient bit each
    logic [DV_W-1:0] dv_rem_reg [DV_N][4];
    logic [DV_W-1:0] dv_den_reg [DV_N][4];
    logic [T_W-1:0]  dv_q_reg   [DV_N][4];
    logic            dv_ovf_reg [DV_N][4];
    logic            dv_visz_reg [DV_N];
    logic            dv_deg_reg  [DV_N];
    logic            dv_v_reg    [DV_N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0][DIV_ANG] <= DV_W'(adot_e3_reg) << (2 * LEN_FRAC + SFB);
            dv_den_reg[0][DIV_ANG] <= DV_W'(prod_reg[MUL_LL]);
            dv_rem_reg[0][DIV_SCL] <= DV_W'(prod_reg[MUL_AS]) << (2 + SFB);
            dv_den_reg[0][DIV_SCL] <= DV_W'(prod_reg[MUL_SS]) + (DV_W'(prod_reg[MUL_AB]) << 2);
            dv_rem_reg[0][DIV_POS] <= DV_W'(s_e3_reg) << SFB;
            dv_den_reg[0][DIV_POS] <= DV_W'(s_e3_reg) + DV_W'(dm_e3_reg);
            dv_rem_reg[0][DIV_VIS] <= DV_W'(visn_e3_reg) << SFB;
            dv_den_reg[0][DIV_VIS] <= DV_W'(adot_e3_reg);
            for (int d = 0; d < 4; d++) begin
                dv_q_reg[0][d]   <= '0;
                dv_ovf_reg[0][d] <= 1'b0;
            end
            dv_visz_reg[0] <= visz_e3_reg;
            dv_deg_reg[0]  <= deg_e3_reg;
        end
    end

    for (genvar t = 1; t < DV_N; t++) begin : g_div
        for (genvar d = 0; d < 4; d++) begin : g_unit
            logic [DV_W-1:0] sub;
            logic            fits;
            if (t == 1) begin : g_ovf
                // quotient at or above 2^(SFB+1) clamps to one anyway
                assign sub  = dv_den_reg[t-1][d] << (SFB + 1);
                assign fits = dv_rem_reg[t-1][d] >= sub;
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_rem_reg[t][d] <= dv_rem_reg[t-1][d];
                        dv_q_reg[t][d]   <= dv_q_reg[t-1][d];
                        dv_ovf_reg[t][d] <= fits;
                    end
                end
            end else begin : g_bit
                localparam int I = DV_N - 1 - t;
                assign sub  = dv_den_reg[t-1][d] << I;
                assign fits = dv_rem_reg[t-1][d] >= sub;
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_rem_reg[t][d] <= fits ? dv_rem_reg[t-1][d] - sub
                                                 : dv_rem_reg[t-1][d];
                        dv_q_reg[t][d]   <= fits ? (dv_q_reg[t-1][d] | (T_W'(1) << I))
                                                 : dv_q_reg[t-1][d];
                        dv_ovf_reg[t][d] <= dv_ovf_reg[t-1][d];
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_den_reg[t][d] <= dv_den_reg[t-1][d];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_visz_reg[t] <= dv_visz_reg[t-1];
                dv_deg_reg[t]  <= dv_deg_reg[t-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[t] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[t] <= dv_v_reg[t-1];
            end
        end
    end

    // ---------------- F1: clamp terms to one; the visibility term is zero when visz is set
    logic [T_W-1:0] term_reg [4];
    logic           deg_f1_reg, v_f1_reg;

    for (genvar d = 0; d < 4; d++) begin : g_clamp
        logic [T_W-1:0] qf;
        logic           big;
        assign qf  = dv_q_reg[DV_N-1][d];
        assign big = dv_ovf_reg[DV_N-1][d] || (qf > ONE);
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (d == DIV_VIS && dv_visz_reg[DV_N-1]) begin
                    term_reg[d] <= '0;
                end else begin
                    term_reg[d] <= big ? ONE : qf;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_f1_reg <= dv_deg_reg[DV_N-1];
        end
    end

    // ---------------- F2..F4: score = ((ang * scl) * pos) * vis, floored each step
    logic [2*T_W-1:0] m1_c, m2_c, m3_c;
    logic [T_W-1:0]   t1_reg, t2_reg, t3_reg;
    logic [T_W-1:0]   pos_f2_reg, vis_f2_reg, vis_f3_reg;
    logic             deg_f2_reg, deg_f3_reg, deg_f4_reg;
    logic             v_f2_reg, v_f3_reg, v_f4_reg;

    always_comb begin
        m1_c = term_reg[DIV_ANG] * term_reg[DIV_SCL];
        m2_c = t1_reg * pos_f2_reg;
        m3_c = t2_reg * vis_f3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg     <= m1_c[SFB +: T_W];
            pos_f2_reg <= term_reg[DIV_POS];
            vis_f2_reg <= term_reg[DIV_VIS];
            deg_f2_reg <= deg_f1_reg;
            t2_reg     <= m2_c[SFB +: T_W];
            vis_f3_reg <= vis_f2_reg;
            deg_f3_reg <= deg_f2_reg;
            t3_reg     <= m3_c[SFB +: T_W];
            deg_f4_reg <= deg_f3_reg;
            out_reg.compatible <= !deg_f4_reg && (CMP_W'(t3_reg) >= CMP_W'(thr_reg));
            out_reg.score      <= deg_f4_reg ? '0 : SCORE_W'(t3_reg);
            out_reg.degenerate <= deg_f4_reg;
        end
    end

    // ---------------- valid bits outside the loops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            v_e1_reg    <= 1'b0;
            v_e2_reg    <= 1'b0;
            v_e3_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            v_f1_reg    <= 1'b0;
            v_f2_reg    <= 1'b0;
            v_f3_reg    <= 1'b0;
            v_f4_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            sq_v_reg[0] <= v3_reg;
            v_e1_reg    <= sq_v_reg[SQ_W];
            v_e2_reg    <= v_e1_reg;
            v_e3_reg    <= v_e2_reg;
            dv_v_reg[0] <= v_e3_reg;
            v_f1_reg    <= dv_v_reg[DV_N-1];
            v_f2_reg    <= v_f1_reg;
            v_f3_reg    <= v_f2_reg;
            v_f4_reg    <= v_f3_reg;
            out_v_reg   <= v_f4_reg;
        end
    end

    // ---------------- checks
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.score == '0 && !m_data.compatible)
        else $error("degenerate result with nonzero score or compatible set");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v_f4_reg))
        else $error("result appeared without a valid item in the last stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_f4_reg) && $stable(t3_reg))
        else $error("last stage moved during a stall");

endmodule
